// ===== rtl/core/kct_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed counter table package
// Shared widths, operation and status codes, and the command bundle that the
// controller sends to the datapath.
// ----------------------------------------------------------------------------
package kct_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 16;
    localparam int COUNT_W  = 31;
    localparam int STATUS_W = 3;

    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PULL  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_ABSENT = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_UNDER  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_OVER   = 3'd4;

    typedef struct packed {
        logic load;
        logic match;
        logic encode;
        logic read;
        logic exec;
    } kct_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/kct_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module kct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== rtl/core/kct_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed counter table controller
// Steps each transaction through key match, encode, count read and update.
// ----------------------------------------------------------------------------
module kct_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output kct_pkg::kct_cmd_t      cmd
);

    import kct_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MATCH  = 5'b00010,
        ST_ENCODE = 5'b00100,
        ST_READ   = 5'b01000,
        ST_EXEC   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:  state_next = ST_ENCODE;
            ST_ENCODE: state_next = ST_READ;
            ST_READ:   state_next = ST_EXEC;
            ST_EXEC:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign cmd.load   = (state_reg == ST_IDLE) && start;
    assign cmd.match  = (state_reg == ST_MATCH);
    assign cmd.encode = (state_reg == ST_ENCODE);
    assign cmd.read   = (state_reg == ST_READ);
    assign cmd.exec   = (state_reg == ST_EXEC);

    a_accept_starts_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.match && busy)
        else $error("accepted transaction did not enter the match step");

    a_exec_frees_port: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> !busy)
        else $error("controller still busy after the update step");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.match, cmd.encode, cmd.read, cmd.exec}))
        else $error("more than one datapath command active");

endmodule
`default_nettype wire

// ===== rtl/core/kct_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed counter table datapath
// Holds the key array, valid bits and count RAM, and computes each update.
// ----------------------------------------------------------------------------
module kct_dp #(
    parameter int ENTRIES = kct_pkg::ENTRIES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire kct_pkg::kct_cmd_t              cmd,
    input  wire logic [kct_pkg::FUNC_W-1:0]     func,
    input  wire logic [kct_pkg::KEY_W-1:0]      item_key,
    input  wire logic [kct_pkg::COUNT_W-1:0]    amount,
    output logic                                done,
    output logic      [kct_pkg::COUNT_W-1:0]    count_after,
    output logic      [kct_pkg::STATUS_W-1:0]   status
);

    import kct_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [FUNC_W-1:0]   func_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [COUNT_W-1:0]  amount_reg;

    logic [KEY_W-1:0]    key_mem_reg [ENTRIES];
    logic [ENTRIES-1:0]  valid_reg;
    logic [ENTRIES-1:0]  valid_next;

    logic [ENTRIES-1:0]  match_vec_reg;
    logic [ENTRIES-1:0]  match_vec_next;
    logic [ENTRIES-1:0]  free_vec_reg;

    logic                hit_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic [IDX_W-1:0]    hit_idx_next;
    logic                full_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic [IDX_W-1:0]    free_idx_next;
    logic [ENTRIES-1:0]  free_low;

    logic [COUNT_W-1:0]  rd_data;
    logic [COUNT_W-1:0]  cur;
    logic [COUNT_W:0]    sum;
    logic [COUNT_W-1:0]  diff;
    logic [COUNT_W-1:0]  res_count;
    logic [STATUS_W-1:0] res_status;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [COUNT_W-1:0]  ram_wdata;
    logic                key_we;
    logic                set_valid;
    logic                clr_valid;

    logic                done_reg;
    logic [COUNT_W-1:0]  count_after_reg;
    logic [STATUS_W-1:0] status_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= func;
            key_reg    <= item_key;
            amount_reg <= amount;
        end
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec_next[i] = valid_reg[i] && (key_mem_reg[i] == key_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.match)
        begin
            match_vec_reg <= match_vec_next;
            free_vec_reg  <= ~valid_reg;
        end
    end

    // The lowest free entry is isolated with a two's complement trick; keys
    // are unique, so the match vector is one-hot or empty and needs no priority.
    assign free_low = free_vec_reg & (~free_vec_reg + ENTRIES'(1));

    always_comb
    begin
        hit_idx_next  = '0;
        free_idx_next = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match_vec_reg[i])
            begin
                hit_idx_next = hit_idx_next | IDX_W'(i);
            end
            if (free_low[i])
            begin
                free_idx_next = free_idx_next | IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.encode)
        begin
            hit_reg      <= |match_vec_reg;
            hit_idx_reg  <= hit_idx_next;
            full_reg     <= ~|free_vec_reg;
            free_idx_reg <= free_idx_next;
        end
    end

    kct_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (cmd.read),
        .rd_addr (hit_idx_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        cur        = hit_reg ? rd_data : '0;
        sum        = {1'b0, cur} + {1'b0, amount_reg};
        diff       = cur - amount_reg;
        res_count  = cur;
        res_status = STAT_OK;
        ram_we     = 1'b0;
        ram_waddr  = hit_idx_reg;
        ram_wdata  = sum[COUNT_W-1:0];
        key_we     = 1'b0;
        set_valid  = 1'b0;
        clr_valid  = 1'b0;
        case (func_reg)
            FUNC_ADD:
            begin
                if (hit_reg)
                begin
                    if (sum[COUNT_W])
                    begin
                        res_status = STAT_OVER;
                    end
                    else
                    begin
                        res_count = sum[COUNT_W-1:0];
                        ram_we    = cmd.exec;
                    end
                end
                else if (amount_reg != '0)
                begin
                    if (full_reg)
                    begin
                        res_status = STAT_FULL;
                    end
                    else
                    begin
                        res_count = amount_reg;
                        ram_we    = cmd.exec;
                        ram_waddr = free_idx_reg;
                        ram_wdata = amount_reg;
                        key_we    = cmd.exec;
                        set_valid = cmd.exec;
                    end
                end
            end
            FUNC_PULL:
            begin
                if (!hit_reg)
                begin
                    res_status = STAT_ABSENT;
                end
                else if (amount_reg > cur)
                begin
                    res_status = STAT_UNDER;
                end
                else
                begin
                    res_count = diff;
                    ram_we    = cmd.exec;
                    ram_wdata = diff;
                    clr_valid = cmd.exec && (diff == '0);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (set_valid)
        begin
            valid_next[free_idx_reg] = 1'b1;
        end
        if (clr_valid)
        begin
            valid_next[hit_idx_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= cmd.exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem_reg[free_idx_reg] <= key_reg;
        end
        if (cmd.exec)
        begin
            count_after_reg <= res_count;
            status_reg      <= res_status;
        end
    end

    assign done        = done_reg;
    assign count_after = count_after_reg;
    assign status      = status_reg;

    a_done_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.exec))
        else $error("result strobe without an update step");

    a_valid_only_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cmd.exec) |-> $stable(valid_reg))
        else $error("valid bits changed outside the update step");

    a_absent_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == STAT_ABSENT || status == STAT_FULL) |-> (count_after == '0))
        else $error("rejected absent key reported a nonzero count");

    a_keys_unique: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.encode |-> $onehot0(match_vec_reg))
        else $error("key held in more than one entry");

endmodule
`default_nettype wire

// ===== rtl/core/keyed_counter_table_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed counter table
// Associative table of key and count pairs with add, pull and query.
// ----------------------------------------------------------------------------
// The result strobe is registered from the update step. A new transaction is
// accepted only when idle; the key match, the encode, the single count RAM read
// and the read-modify-write run one after another.
// The receiver cannot stall; done is high for exactly one cycle per result.
// Reset clears all valid bits at once, so the table is empty right after it.
// ----------------------------------------------------------------------------
module keyed_counter_table_top #(
    parameter int ENTRIES = kct_pkg::ENTRIES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [kct_pkg::FUNC_W-1:0]     func,
    input  wire logic [kct_pkg::KEY_W-1:0]      item_key,
    input  wire logic [kct_pkg::COUNT_W-1:0]    amount,
    output logic                                done,
    output logic      [kct_pkg::COUNT_W-1:0]    count_after,
    output logic      [kct_pkg::STATUS_W-1:0]   status
);

    import kct_pkg::*;

    kct_cmd_t cmd;

    kct_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    kct_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .func        (func),
        .item_key    (item_key),
        .amount      (amount),
        .done        (done),
        .count_after (count_after),
        .status      (status)
    );

endmodule
`default_nettype wire
